### hdl/udm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udm_pkg
// Shared widths, constants and inter-module structs of the magic-number core.
// ----------------------------------------------------------------------------
package udm_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned P_W     = 7;                // holds exponent 31..64
  localparam int unsigned CNT_W   = $clog2(WORD_W);   // bit counter of the divider

  localparam logic [WORD_W-1:0] HALF_POW    = 32'h8000_0000;
  localparam logic [WORD_W-1:0] HALF_POW_M1 = 32'h7FFF_FFFF;
  localparam logic [P_W-1:0]    P_START     = 7'd31;
  localparam logic [P_W-1:0]    P_LIMIT     = 7'd64;
  localparam logic [P_W-1:0]    P_WORD      = 7'd32;

  // request to the serial divider (start is a one-cycle pulse)
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] rem;
  } div_rsp_t;

  // control of the refinement unit
  typedef struct packed {
    logic load1;   // take quotient/remainder pair of 2^31 / nc
    logic start;   // take pair of (2^31-1) / d and begin stepping
  } ref_ctl_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] q2;
    logic              add;
    logic [P_W-1:0]    p;
  } ref_sts_t;

endpackage

`default_nettype wire

### hdl/udm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udm_if
// Valid/ready channels of the magic-number core: divisor in, result out.
// ----------------------------------------------------------------------------
interface udm_in_if
  import udm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] divisor;

  modport source (output valid, output divisor, input ready);
  modport sink   (input valid, input divisor, output ready);
endinterface

interface udm_out_if
  import udm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  magic;
  logic               add_needed;
  logic [SHIFT_W-1:0] shift;
  logic               is_power_of_two;
  logic               invalid;

  modport source (output valid, output magic, output add_needed, output shift,
                  output is_power_of_two, output invalid, input ready);
  modport sink   (input valid, input magic, input add_needed, input shift,
                  input is_power_of_two, input invalid, output ready);
endinterface

`default_nettype wire

### hdl/udm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udm_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module udm_div
  import udm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [WORD_W-1:0] qr_q;      // dividend shifts out, quotient shifts in
  logic [WORD_W-1:0] rem_q;
  logic [WORD_W-1:0] dvs_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [WORD_W:0] part;
  logic [WORD_W:0] diff;
  logic            ge;

  always_comb begin
    part = {rem_q, qr_q[WORD_W-1]};
    diff = part - {1'b0, dvs_q};
    ge   = ~diff[WORD_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qr_q   <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        qr_q   <= req_i.dividend;
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
        cnt_q  <= CNT_W'(WORD_W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        qr_q  <= {qr_q[WORD_W-2:0], ge};
        rem_q <= ge ? diff[WORD_W-1:0] : part[WORD_W-1:0];
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign rsp_o = '{done: done_q, quot: qr_q, rem: rem_q};

endmodule

`default_nettype wire

### hdl/udm_refine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udm_refine
// Refines both quotient/remainder pairs one exponent bit per cycle until the
// exit test holds or p reaches 64.
// ----------------------------------------------------------------------------
module udm_refine
  import udm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ref_ctl_t          ctl_i,
  input  wire logic [WORD_W-1:0] d_i,
  input  wire logic [WORD_W-1:0] nc_i,
  input  wire div_rsp_t          div_i,
  output ref_sts_t               sts_o
);

  logic [WORD_W-1:0] q1_q, r1_q, q2_q, r2_q, dm1_q;
  logic [P_W-1:0]    p_q;
  logic              add_q;
  logic              run_q;
  logic              first_q;
  logic              done_q;

  logic [WORD_W-1:0] q1_d, r1_d, q2_d, r2_d, delta;
  logic              add_set;
  logic              go_on;

  always_comb begin
    if (r1_q >= (nc_i - r1_q)) begin
      q1_d = {q1_q[WORD_W-2:0], 1'b1};
      r1_d = {r1_q[WORD_W-2:0], 1'b0} - nc_i;
    end else begin
      q1_d = {q1_q[WORD_W-2:0], 1'b0};
      r1_d = {r1_q[WORD_W-2:0], 1'b0};
    end
    if ((r2_q + 1'b1) >= (d_i - r2_q)) begin
      add_set = (q2_q >= HALF_POW_M1);
      q2_d    = {q2_q[WORD_W-2:0], 1'b1};
      r2_d    = {r2_q[WORD_W-2:0], 1'b1} - d_i;
    end else begin
      add_set = (q2_q >= HALF_POW);
      q2_d    = {q2_q[WORD_W-2:0], 1'b0};
      r2_d    = {r2_q[WORD_W-2:0], 1'b1};
    end
    // exit test is evaluated on the registered result of the previous step
    delta = dm1_q - r2_q;
    go_on = (p_q < P_LIMIT) && ((q1_q < delta) || ((q1_q == delta) && (r1_q == '0)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_q    <= '0;
      r1_q    <= '0;
      q2_q    <= '0;
      r2_q    <= '0;
      dm1_q   <= '0;
      p_q     <= '0;
      add_q   <= 1'b0;
      run_q   <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.load1) begin
        q1_q <= div_i.quot;
        r1_q <= div_i.rem;
      end
      if (ctl_i.start) begin
        q2_q    <= div_i.quot;
        r2_q    <= div_i.rem;
        dm1_q   <= d_i - 1'b1;
        p_q     <= P_START;
        add_q   <= 1'b0;
        run_q   <= 1'b1;
        first_q <= 1'b1;
      end else if (run_q) begin
        if (first_q || go_on) begin
          first_q <= 1'b0;
          q1_q    <= q1_d;
          r1_q    <= r1_d;
          q2_q    <= q2_d;
          r2_q    <= r2_d;
          p_q     <= p_q + 1'b1;
          add_q   <= add_q | add_set;
        end else begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o = '{done: done_q, q2: q2_q, add: add_q, p: p_q};

endmodule

`default_nettype wire

### hdl/unsigned_division_magic_number_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_division_magic_number_core
// Magic multiplier, add flag and post-shift for unsigned division by a constant.
// ----------------------------------------------------------------------------
// One divisor is taken at a time; the next is accepted the cycle after the
// previous result has moved into the output register. A general divisor runs
// three passes of a shared bit-serial divider (each: request, load, 32 bit
// steps and hand-off) and then the refinement unit, which steps the exponent
// until its exit test ends the run, before its result reaches the output
// register. A power of two 2^k finds k by shifting in its own state, and a
// divisor below 2 goes straight to the result state. For a general divisor
// the result is x / d = ((hi(x * magic) + (add_needed ? x : 0)) >> shift),
// the add done at 33 bits; a power of two carries a zero magic and its shift.
// ----------------------------------------------------------------------------
module unsigned_division_magic_number_core
  import udm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  udm_in_if.sink    in_ch_i,
  udm_out_if.source out_ch_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW2,
    ST_DIV_NC,
    ST_DIV_Q1,
    ST_DIV_Q2,
    ST_REFINE,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [WORD_W-1:0]  d_q;
  logic [WORD_W-1:0]  nc_q;
  logic [WORD_W-1:0]  t_q;
  logic [SHIFT_W-1:0] k_q;
  logic               inv_q;
  logic               pow2_q;
  div_req_t           div_req_q;
  div_rsp_t           div_rsp;
  ref_ctl_t           ref_ctl;
  ref_sts_t           ref_sts;

  logic               out_valid_q;
  logic [WORD_W-1:0]  magic_q;
  logic               add_q;
  logic [SHIFT_W-1:0] shift_q;
  logic               pow2_out_q;
  logic               inv_out_q;

  logic               in_xfer;
  logic               d_small;
  logic               d_pow2;
  logic [P_W-1:0]     p_shift;

  assign in_xfer = in_ch_i.valid && in_ch_i.ready;
  assign d_small = (in_ch_i.divisor[WORD_W-1:1] == '0);
  assign d_pow2  = ((in_ch_i.divisor & (in_ch_i.divisor - 1'b1)) == '0);
  assign p_shift = ref_sts.p - P_WORD;

  assign ref_ctl = '{load1: (state_q == ST_DIV_Q1) && div_rsp.done,
                     start: (state_q == ST_DIV_Q2) && div_rsp.done};

  udm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  udm_refine u_refine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ref_ctl),
    .d_i    (d_q),
    .nc_i   (nc_q),
    .div_i  (div_rsp),
    .sts_o  (ref_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      d_q         <= '0;
      nc_q        <= '0;
      t_q         <= '0;
      k_q         <= '0;
      inv_q       <= 1'b0;
      pow2_q      <= 1'b0;
      div_req_q   <= '0;
      out_valid_q <= 1'b0;
      magic_q     <= '0;
      add_q       <= 1'b0;
      shift_q     <= '0;
      pow2_out_q  <= 1'b0;
      inv_out_q   <= 1'b0;
    end else begin
      div_req_q.start <= 1'b0;
      if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            d_q    <= in_ch_i.divisor;
            t_q    <= in_ch_i.divisor;
            k_q    <= '0;
            inv_q  <= d_small;
            pow2_q <= !d_small && d_pow2;
            if (d_small) begin
              state_q <= ST_DONE;
            end else if (d_pow2) begin
              state_q <= ST_POW2;
            end else begin
              // nc needs (2^32 - d) mod d
              div_req_q <= '{start: 1'b1, dividend: '0 - in_ch_i.divisor,
                             divisor: in_ch_i.divisor};
              state_q   <= ST_DIV_NC;
            end
          end
        end
        ST_POW2: begin
          if (t_q[WORD_W-1:1] != '0) begin
            t_q <= t_q >> 1;
            k_q <= k_q + 1'b1;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DIV_NC: begin
          if (div_rsp.done) begin
            nc_q      <= ~div_rsp.rem;
            div_req_q <= '{start: 1'b1, dividend: HALF_POW, divisor: ~div_rsp.rem};
            state_q   <= ST_DIV_Q1;
          end
        end
        ST_DIV_Q1: begin
          if (div_rsp.done) begin
            div_req_q <= '{start: 1'b1, dividend: HALF_POW_M1, divisor: d_q};
            state_q   <= ST_DIV_Q2;
          end
        end
        ST_DIV_Q2: begin
          if (div_rsp.done) begin
            state_q <= ST_REFINE;
          end
        end
        ST_REFINE: begin
          if (ref_sts.done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ch_o.ready) begin
            out_valid_q <= 1'b1;
            inv_out_q   <= inv_q;
            pow2_out_q  <= pow2_q;
            if (inv_q) begin
              magic_q <= '0;
              add_q   <= 1'b0;
              shift_q <= '0;
            end else if (pow2_q) begin
              magic_q <= '0;
              add_q   <= 1'b0;
              shift_q <= k_q;
            end else begin
              magic_q <= ref_sts.q2 + 1'b1;
              add_q   <= ref_sts.add;
              shift_q <= p_shift[SHIFT_W-1:0];
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch_i.ready            = (state_q == ST_IDLE);
  assign out_ch_o.valid           = out_valid_q;
  assign out_ch_o.magic           = magic_q;
  assign out_ch_o.add_needed      = add_q;
  assign out_ch_o.shift           = shift_q;
  assign out_ch_o.is_power_of_two = pow2_out_q;
  assign out_ch_o.invalid         = inv_out_q;

`ifndef SYNTHESIS
  // an invalid divisor carries an all-zero result
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && inv_out_q) |->
      (magic_q == '0 && shift_q == '0 && !add_q && !pow2_out_q))
    else $error("invalid result with nonzero fields");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |->
      (state_q == ST_DIV_NC || state_q == ST_DIV_Q1 || state_q == ST_DIV_Q2))
    else $error("divider finished outside a division state");

  a_ref_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_sts.done |-> (state_q == ST_REFINE))
    else $error("refinement finished outside refine state");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (shift_q <= SHIFT_W'(WORD_W)))
    else $error("post-shift out of range");
`endif

endmodule

`default_nettype wire

### verif/udm_magic_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udm_magic_checker
// Watches both channels of the magic-number core, predicts the magic multiplier,
// add flag, shift and status flags of each accepted divisor and compares every
// result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module udm_magic_checker
  import udm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [WORD_W-1:0]  divisor_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic [WORD_W-1:0]  magic_i,
  input  wire logic               add_needed_i,
  input  wire logic [SHIFT_W-1:0] shift_i,
  input  wire logic               is_power_of_two_i,
  input  wire logic               invalid_i,
  output int unsigned             pending_o,
  output int unsigned             fail_count_o
);

  typedef struct packed {
    logic [WORD_W-1:0]  magic;
    logic               add_needed;
    logic [SHIFT_W-1:0] shift;
    logic               is_power_of_two;
    logic               invalid;
  } magic_result_t;

  magic_result_t expected_results[$];
  magic_result_t oldest;
  int unsigned   mismatches;

  function automatic magic_result_t predict_magic(input logic [WORD_W-1:0] d);
    magic_result_t     res;
    logic [WORD_W-1:0] nc, delta, q1, r1, q2, r2, neg_d;
    logic [P_W-1:0]    p;
    logic              add_f;
    logic              keep_going;
    res = '0;
    if (d < 2) begin
      res.invalid = 1'b1;
    end else if ((d & (d - 1)) == '0) begin
      res.is_power_of_two = 1'b1;
      res.shift           = SHIFT_W'($clog2(d));
    end else begin
      neg_d = WORD_W'(0) - d;
      nc    = {WORD_W{1'b1}} - (neg_d % d);
      q1    = HALF_POW / nc;
      r1    = HALF_POW - q1 * nc;
      q2    = HALF_POW_M1 / d;
      r2    = HALF_POW_M1 - q2 * d;
      p     = P_START;
      add_f = 1'b0;
      keep_going = 1'b1;
      while (keep_going) begin
        p = p + 1'b1;
        if (r1 >= WORD_W'(nc - r1)) begin
          q1 = (q1 << 1) + 32'd1;
          r1 = (r1 << 1) - nc;
        end else begin
          q1 = q1 << 1;
          r1 = r1 << 1;
        end
        // 32-bit wrap on both sides of the compare
        if (WORD_W'(r2 + 32'd1) >= WORD_W'(d - r2)) begin
          if (q2 >= HALF_POW_M1) add_f = 1'b1;
          q2 = (q2 << 1) + 32'd1;
          r2 = (r2 << 1) + 32'd1 - d;
        end else begin
          if (q2 >= HALF_POW) add_f = 1'b1;
          q2 = q2 << 1;
          r2 = (r2 << 1) + 32'd1;
        end
        delta      = d - 32'd1 - r2;
        keep_going = (p < P_LIMIT) && ((q1 < delta) || ((q1 == delta) && (r1 == '0)));
      end
      res.magic      = q2 + 32'd1;
      res.add_needed = add_f;
      res.shift      = SHIFT_W'(p - P_WORD);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // retire first so a result can never match a divisor taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no divisor outstanding: magic %h", magic_i);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          if (magic_i !== oldest.magic) begin
            $error("magic: expected %h, got %h", oldest.magic, magic_i);
            mismatches++;
          end
          if (add_needed_i !== oldest.add_needed) begin
            $error("add_needed: expected %0d, got %0d", oldest.add_needed, add_needed_i);
            mismatches++;
          end
          if (shift_i !== oldest.shift) begin
            $error("shift: expected %0d, got %0d", oldest.shift, shift_i);
            mismatches++;
          end
          if (is_power_of_two_i !== oldest.is_power_of_two) begin
            $error("is_power_of_two: expected %0d, got %0d",
                   oldest.is_power_of_two, is_power_of_two_i);
            mismatches++;
          end
          if (invalid_i !== oldest.invalid) begin
            $error("invalid: expected %0d, got %0d", oldest.invalid, invalid_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_results.push_back(predict_magic(divisor_i));
      pending_o    <= expected_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

`default_nettype wire

### verif/unsigned_division_magic_number_core_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_division_magic_number_core_tb
// Feeds corner and random divisors to the magic-number core with random idle
// cycles on both channels, one long result stall and three full drains, and lets
// the checker compare every result.
// ----------------------------------------------------------------------------
module unsigned_division_magic_number_core_tb;
  import udm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1580;
  localparam int unsigned DRAIN_AT     = 800;   // random item before which the sender drains
  localparam int unsigned BURST_FROM   = 1000;  // back-to-back stretch of the sender
  localparam int unsigned BURST_TO     = 1200;
  localparam int unsigned HOLD_AFTER   = 300;   // results seen before the long stall
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned SETTLE       = 200;

  localparam logic [WORD_W-1:0] CORNER_DIVISORS [22] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
    32'h0000_0005, 32'h0000_0006, 32'h0000_0007, 32'h0000_0004,
    32'h0000_000A, 32'h0000_0281, 32'h0000_03E8, 32'h0000_0019,
    32'h4000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001,
    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA,
    32'hC000_0000, 32'h0000_0007
  };

  logic        clk_i;
  logic        rst_ni;
  int unsigned pending;
  int unsigned fail_count;

  udm_in_if  in_ch ();
  udm_out_if out_ch ();

  unsigned_division_magic_number_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  udm_magic_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_ch.valid),
    .in_ready_i        (in_ch.ready),
    .divisor_i         (in_ch.divisor),
    .out_valid_i       (out_ch.valid),
    .out_ready_i       (out_ch.ready),
    .magic_i           (out_ch.magic),
    .add_needed_i      (out_ch.add_needed),
    .shift_i           (out_ch.shift),
    .is_power_of_two_i (out_ch.is_power_of_two),
    .invalid_i         (out_ch.invalid),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [WORD_W-1:0] random_divisor();
    int unsigned       r;
    logic [WORD_W-1:0] pow;
    r   = $urandom_range(0, 99);
    pow = WORD_W'(1) << $urandom_range(0, 31);
    if (r < 35) return $urandom;
    if (r < 55) return $urandom_range(2, 1000);
    if (r < 70) return pow + WORD_W'(1) - WORD_W'($urandom_range(0, 2));
    if (r < 80) return $urandom >> $urandom_range(1, 31);
    if (r < 90) return 32'hFFFF_FFFF - WORD_W'($urandom_range(0, 1000));
    if (r < 96) return pow;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_divisor(input logic [WORD_W-1:0] d, input int unsigned gap);
    in_ch.valid   <= 1'b1;
    in_ch.divisor <= d;
    do @(posedge clk_i); while (!in_ch.ready);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid and wait until every predicted result has been taken
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // result side: random ready bursts, one long stall, one stretch with no stalls
  initial begin
    int unsigned seen;
    int unsigned burst;
    int unsigned gap;
    bit          held;
    out_ch.ready <= 1'b0;
    seen = 0;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      burst = $urandom_range(1, 40);
      out_ch.ready <= 1'b1;
      repeat (burst) begin
        @(posedge clk_i);
        if (out_ch.valid && out_ch.ready) seen++;
      end
      if (!held && seen >= HOLD_AFTER) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else if (seen >= 900 && seen < 1100) begin
        gap = 0;
      end else begin
        gap = idle_cycles();
      end
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.divisor <= '0;
    wait (rst_ni);
    @(posedge clk_i);

    foreach (CORNER_DIVISORS[i]) send_divisor(CORNER_DIVISORS[i], idle_cycles());
    drain_results();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == DRAIN_AT) drain_results();
      send_divisor(random_divisor(),
                   (n >= BURST_FROM && n < BURST_TO) ? 0 : idle_cycles());
    end

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog that ends a hung run as failed
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
